// ===== rtl/hs_pkg.sv =====
// ----------------------------------------------------------------------------
// hs_pkg
// shared constants and types of the sorter: item layouts, cell links and
// the control word that the top level broadcasts to the cell row
// ----------------------------------------------------------------------------
`default_nettype none

package hs_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last;
   } hs_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         last_out;
      logic                         overflow;
   } hs_rsp_type;

   // contents of one cell as seen by its neighbors
   typedef struct packed {
      logic                         valid;
      logic signed [DATA_WIDTH-1:0] value;
   } hs_cell_type;

   // broadcast to every cell
   typedef struct packed {
      logic                         insert;
      logic                         shift;
      logic signed [DATA_WIDTH-1:0] value;
   } hs_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/heap_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// heap_sorter_unit
// collects a data set of signed values and returns it in ascending order
// ----------------------------------------------------------------------------
// usage:
//   an item is taken when start is high and busy is low. each item carries
//   one value and a last flag. values go straight into a row of DEPTH
//   cells that keeps them in ascending order; an item can be taken on
//   every clock while busy is low. values beyond DEPTH are dropped and
//   flag overflow. on the clock after the last item the row drains from
//   its low end: rsp_strobe is high while draining, one stored value per
//   cycle, smallest first, last_out on the final one and overflow on all
//   of them if anything was dropped. busy is high while draining. the
//   drain shifts the row down toward cell 0, whose value is the output.
//   results cannot be held off by the receiver.
//   reset empties the row and clears the count and overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sorter_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire hs_pkg::hs_req_type req_item,
   output logic                    busy,
   output logic                    rsp_strobe,
   output hs_pkg::hs_rsp_type      rsp_item
);
   import hs_pkg::*;

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic             state_ff;
   logic             state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             overflow_ff;
   logic             overflow_in;
   logic             accept;
   logic             room;
   hs_ctrl_type      ctrl;
   hs_cell_type      cells [DEPTH];
   logic             gts   [DEPTH];

   assign busy   = (state_ff == ST_DRAIN);
   assign accept = start && !busy;
   assign room   = (count_ff != CNT_W'(DEPTH));

   assign ctrl.insert = accept && room;
   assign ctrl.shift  = busy;
   assign ctrl.value  = req_item.value;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_item.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            count_in = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               state_in    = ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      hs_cell_type prev_cell;
      logic        prev_gt;
      hs_cell_type next_cell;

      if (i == 0) begin : g_head
         assign prev_cell = '0;
         assign prev_gt   = 1'b0;
      end else begin : g_body
         assign prev_cell = cells[i-1];
         assign prev_gt   = gts[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_cell = '0;
      end else begin : g_link
         assign next_cell = cells[i+1];
      end

      hs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .prev_cell (prev_cell),
         .prev_gt   (prev_gt),
         .next_cell (next_cell),
         .slot      (cells[i]),
         .gt        (gts[i])
      );
   end

   assign rsp_strobe            = busy;
   assign rsp_item.sorted_value = cells[0].value;
   assign rsp_item.last_out     = busy && (count_ff == CNT_W'(1));
   assign rsp_item.overflow     = overflow_ff;

`ifndef SYNTHESIS
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (count_ff != '0) && cells[0].valid)
      else $error("drain with empty row");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count beyond depth");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last_out |=> !busy && (count_ff == '0) && !overflow_ff)
      else $error("set not closed after final item");

   a_drop_flags: assert property (@(posedge clock) disable iff (reset)
      accept && !room |=> overflow_ff)
      else $error("dropped item not flagged");
`endif

endmodule

`default_nettype wire

// ===== rtl/hs_cell.sv =====
// ----------------------------------------------------------------------------
// hs_cell
// one slot of the sorted row; on insert it keeps its value, takes the left
// neighbor's value or takes the new item, on shift it takes the right one
// ----------------------------------------------------------------------------
`default_nettype none

module hs_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hs_pkg::hs_ctrl_type ctrl,
   input  wire hs_pkg::hs_cell_type prev_cell,
   input  wire logic                prev_gt,
   input  wire hs_pkg::hs_cell_type next_cell,
   output hs_pkg::hs_cell_type      slot,
   output logic                     gt
);
   import hs_pkg::*;

   logic                         valid_ff;
   logic                         valid_in;
   logic signed [DATA_WIDTH-1:0] value_ff;
   logic signed [DATA_WIDTH-1:0] value_in;

   // empty slots count as greater than anything
   assign gt = !valid_ff || (value_ff > ctrl.value);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.shift) begin
         valid_in = next_cell.valid;
         value_in = next_cell.value;
      end else if (ctrl.insert && gt) begin
         if (prev_gt) begin
            valid_in = prev_cell.valid;
            value_in = prev_cell.value;
         end else begin
            valid_in = 1'b1;
            value_in = ctrl.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign slot.valid = valid_ff;
   assign slot.value = value_ff;

endmodule

`default_nettype wire
